// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge while reset is released.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bsw_pkg.sv =====
package bsw_pkg;

  localparam int ADC_W        = 10;
  localparam int VREF_W       = 13;
  localparam int PPM_W        = 15;
  localparam int BAC_W        = 20;
  localparam int LED_W        = 5;
  localparam int W_W          = 16;
  localparam int ACC_W        = 48;
  localparam int WSUM_W       = 42;
  localparam int WTS_W        = 22;
  localparam int DIV_N        = 48;
  localparam int DIV_D        = 22;
  localparam int DIV_CNT_W    = $clog2(DIV_N + 1);
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 15;

  localparam int SAMPLE_COUNT     = 64;
  localparam int SAMPLE_PERIOD_MS = 100;
  localparam int INFLECTION_MS    = 3000;
  localparam int IDX_W            = $clog2(SAMPLE_COUNT);

  localparam logic [CFG_IDX_W-1:0] CFG_VREF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 2'd2;

  localparam logic [VREF_W-1:0] VREF_RESET = 13'd5000;
  localparam logic [PPM_W-1:0]  MIN_RESET  = 15'd0;
  localparam logic [PPM_W-1:0]  MAX_RESET  = 15'd32767;

  // Voltage: code*vref*8192/1023000 == code*vref*1024/127875.
  // Estimate with floor(2^34/127875), product shifted down by 24, then fix by one.
  localparam logic [16:0] V_DEN   = 17'd127875;
  localparam logic [17:0] V_RECIP = 18'd134348;
  // bac: ppm/2600 == (ppm>>3)/325. Estimate with floor(2^36/325), then fix by one.
  localparam logic [8:0]  B_DEN   = 9'd325;
  localparam logic [27:0] B_RECIP = 28'd211444543;

  localparam logic signed [ACC_W-1:0] CO5 = 48'sd9858915;
  localparam logic signed [ACC_W-1:0] CO4 = -48'sd147112583;
  localparam logic signed [ACC_W-1:0] CO3 = 48'sd872186767;
  localparam logic signed [ACC_W-1:0] CO2 = -48'sd2564822528;
  localparam logic signed [ACC_W-1:0] CO1 = 48'sd3740966964;
  localparam logic signed [ACC_W-1:0] CO0 = -48'sd2161511847;
  localparam logic signed [ACC_W-1:0] LIM48 = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] MIN48 = {1'b1, {(ACC_W-1){1'b0}}};

  typedef logic [SAMPLE_COUNT-1:0][W_W-1:0] weight_rom_t;

  typedef struct packed {
    logic              start;
    logic [ADC_W-1:0]  adc;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } fifo_rsp_t;

  typedef struct packed {
    logic [1:0] count;
  } front_stat_t;

  typedef struct packed {
    logic             start;
    logic [DIV_N-1:0] dividend;
    logic [DIV_D-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_N-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic             valid;
    logic [BAC_W-1:0] bac;
    logic [LED_W-1:0] leds;
    logic             over;
    logic             last;
  } result_t;

  // Horner coefficients after the leading one, highest order first.
  function automatic logic signed [ACC_W-1:0] coef_of(input logic [2:0] k);
    logic signed [ACC_W-1:0] c;
    case (k)
      3'd0:    c = CO4;
      3'd1:    c = CO3;
      3'd2:    c = CO2;
      3'd3:    c = CO1;
      default: c = CO0;
    endcase
    return c;
  endfunction

  function automatic longint angle_of(input int k);
    longint a;
    case (k)
      0:       a = 16384;
      1:       a = 9672;
      2:       a = 5110;
      3:       a = 2594;
      4:       a = 1302;
      5:       a = 652;
      6:       a = 326;
      7:       a = 163;
      8:       a = 81;
      9:       a = 41;
      10:      a = 20;
      11:      a = 10;
      12:      a = 5;
      13:      a = 3;
      default: a = 1;
    endcase
    return a;
  endfunction

  // Arctangent weight per sample number, resolved at elaboration.
  function automatic weight_rom_t build_weights();
    weight_rom_t rom;
    longint xs, ys, z, dx, dy;
    int i, k;
    for (i = 0; i < SAMPLE_COUNT; i++) begin
      xs = longint'(1000) * 1024;
      ys = (longint'(i) * SAMPLE_PERIOD_MS - INFLECTION_MS) * 1024;
      z  = 0;
      for (k = 0; k < 16; k++) begin
        dx = ys >>> k;
        dy = xs >>> k;
        if (ys > 0) begin
          xs = xs + dx;
          ys = ys - dy;
          z  = z + angle_of(k);
        end else if (ys < 0) begin
          xs = xs - dx;
          ys = ys + dy;
          z  = z - angle_of(k);
        end
      end
      z = z + 32768;
      if (z < 0) z = 0;
      if (z > 65535) z = 65535;
      rom[i] = W_W'(z);
    end
    return rom;
  endfunction

  localparam weight_rom_t WEIGHT_ROM = build_weights();

  function automatic logic [LED_W-1:0] leds_of(input logic [IDX_W-1:0] idx);
    int lit;
    lit = (int'(idx) * 5) / SAMPLE_COUNT + 1;
    if (lit > 5) lit = 5;
    return LED_W'((1 << lit) - 1);
  endfunction

endpackage

// ===== rtl/bsw_front.sv =====
module bsw_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  bsw_pkg::q_item_t        in_item_i,
  output bsw_pkg::fifo_rsp_t      fifo_o,
  input  logic                    pop_i,
  output bsw_pkg::front_stat_t    stat_o
);

  bsw_pkg::q_item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;

  assign fifo_o.valid = (cnt_q != 2'd0);
  assign fifo_o.item  = mem_q[rd_ptr_q];
  assign stat_o.count = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule

// ===== rtl/bsw_div.sv =====
module bsw_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsw_pkg::div_req_t req_i,
  output bsw_pkg::div_rsp_t rsp_o
);

  logic [bsw_pkg::DIV_D-1:0]     rem_q, div_q;
  logic [bsw_pkg::DIV_N-1:0]     quo_q;
  logic [bsw_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          busy_q, done_q;
  logic [bsw_pkg::DIV_D:0]       trial, diff;
  logic                          take;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem_q, quo_q[bsw_pkg::DIV_N-1]};
  assign diff  = trial - {1'b0, div_q};
  assign take  = (trial >= {1'b0, div_q});

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= take ? diff[bsw_pkg::DIV_D-1:0] : trial[bsw_pkg::DIV_D-1:0];
      quo_q <= {quo_q[bsw_pkg::DIV_N-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == bsw_pkg::DIV_CNT_W'(bsw_pkg::DIV_N - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/bsw_back.sv =====
module bsw_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bsw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bsw_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  bsw_pkg::fifo_rsp_t                 fifo_i,
  output logic                               pop_o,
  output bsw_pkg::result_t                   res_o,
  input  logic                               res_ready_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_VMUL  = 4'd1;
  localparam logic [3:0] S_VFIX  = 4'd2;
  localparam logic [3:0] S_MLO   = 4'd3;
  localparam logic [3:0] S_MHI   = 4'd4;
  localparam logic [3:0] S_ADD   = 4'd5;
  localparam logic [3:0] S_CLASS = 4'd6;
  localparam logic [3:0] S_BMUL  = 4'd7;
  localparam logic [3:0] S_BFIX  = 4'd8;
  localparam logic [3:0] S_ACC   = 4'd9;
  localparam logic [3:0] S_MEAN  = 4'd10;
  localparam logic [3:0] S_MDIV  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]                        state_q;
  logic [bsw_pkg::VREF_W-1:0]        vref_q;
  logic [bsw_pkg::PPM_W-1:0]         min_q, max_q;
  logic [22:0]                       vx_q;
  logic [55:0]                       prod_q;
  logic [15:0]                       v_q;
  logic signed [bsw_pkg::ACC_W-1:0]  acc_q;
  logic [2:0]                        k_q;
  logic [40:0]                       plo_q;
  logic signed [41:0]                phi_q;
  logic [bsw_pkg::BAC_W-1:0]         bac_q, mean_q;
  logic                              over_q;
  logic [bsw_pkg::IDX_W-1:0]         idx_q;
  logic [bsw_pkg::WSUM_W-1:0]        wsum_q;
  logic [bsw_pkg::WTS_W-1:0]         wts_q;
  bsw_pkg::result_t                  res_q;
  bsw_pkg::div_req_t                 div_req_q;
  bsw_pkg::div_rsp_t                 div_rsp;

  logic signed [24:0]                mul_a;
  logic signed [41:0]                mul_p;
  logic signed [65:0]                full, sum;
  logic [22:0]                       vprod;
  logic [40:0]                       vmul;
  logic [16:0]                       vq0, vq;
  logic [33:0]                       vrem;
  logic [27:0]                       p8, brem;
  logic [55:0]                       bmul;
  logic [bsw_pkg::BAC_W-1:0]         bq0;
  logic [bsw_pkg::W_W-1:0]           w;
  logic [35:0]                       bw;
  logic [bsw_pkg::WSUM_W:0]          wsum_n;
  logic [bsw_pkg::WTS_W:0]           wts_n;
  logic                              last;
  logic                              out_free;

  bsw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  assign pop_o = (state_q == S_IDLE) && fifo_i.valid;

  // Split the 48-bit by 16-bit product into low and high halves.
  assign mul_a = (state_q == S_MLO) ? $signed({1'b0, acc_q[23:0]}) :
                                      $signed({acc_q[47], acc_q[47:24]});
  assign mul_p = mul_a * $signed({1'b0, v_q});
  assign full  = (66'(phi_q) <<< 24) + $signed({25'b0, plo_q});
  assign sum   = (full >>> 13) + 66'(bsw_pkg::coef_of(k_q));

  assign vprod  = fifo_i.item.adc * vref_q;

  // Voltage by reciprocal: the estimate is exact or one low.
  assign vmul = vx_q * bsw_pkg::V_RECIP;
  assign vq0  = prod_q[40:24];
  assign vrem = {1'b0, vx_q, 10'b0} - vq0 * bsw_pkg::V_DEN;
  assign vq   = vq0 + 17'(vrem >= 34'(bsw_pkg::V_DEN));

  // ppm to bac by reciprocal; ppm is non-negative and below 2^31 here.
  assign p8   = acc_q[30:3];
  assign bmul = p8 * bsw_pkg::B_RECIP;
  assign bq0  = prod_q[55:36];
  assign brem = p8 - bq0 * bsw_pkg::B_DEN;

  assign w      = bsw_pkg::WEIGHT_ROM[idx_q];
  assign bw     = bac_q * w;
  assign wsum_n = {1'b0, wsum_q} + (bsw_pkg::WSUM_W + 1)'(bw);
  assign wts_n  = {1'b0, wts_q} + (bsw_pkg::WTS_W + 1)'(w);
  assign last   = (idx_q == bsw_pkg::IDX_W'(bsw_pkg::SAMPLE_COUNT - 1));
  assign out_free = !res_q.valid || res_ready_i;

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vref_q <= bsw_pkg::VREF_RESET;
      min_q  <= bsw_pkg::MIN_RESET;
      max_q  <= bsw_pkg::MAX_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bsw_pkg::CFG_VREF: vref_q <= cfg_data_i[bsw_pkg::VREF_W-1:0];
        bsw_pkg::CFG_MIN:  min_q  <= cfg_data_i;
        bsw_pkg::CFG_MAX:  max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE:  if (fifo_i.valid) vx_q <= vprod;
      S_VMUL:  prod_q <= 56'(vmul);
      S_VFIX: begin
        v_q   <= (vq > 17'hFFFF) ? 16'hFFFF : vq[15:0];
        acc_q <= bsw_pkg::CO5;
        k_q   <= 3'd0;
      end
      S_MLO:   plo_q <= mul_p[40:0];
      S_MHI:   phi_q <= mul_p;
      S_ADD: begin
        if (sum > 66'(bsw_pkg::LIM48)) acc_q <= bsw_pkg::LIM48;
        else if (sum < 66'(bsw_pkg::MIN48)) acc_q <= bsw_pkg::MIN48;
        else acc_q <= sum[bsw_pkg::ACC_W-1:0];
        k_q <= k_q + 3'd1;
      end
      S_CLASS: begin
        bac_q  <= '0;
        over_q <= 1'b0;
        if (!(acc_q < $signed({17'b0, min_q, 16'b0})) &&
            (acc_q > $signed({17'b0, max_q, 16'b0}))) over_q <= 1'b1;
      end
      S_BMUL:  prod_q <= bmul;
      S_BFIX:  bac_q <= bq0 + bsw_pkg::BAC_W'(brem >= 28'(bsw_pkg::B_DEN));
      S_ACC:   ;
      S_MEAN:  mean_q <= '0;
      S_MDIV:  if (div_rsp.done) mean_q <= div_rsp.quot[bsw_pkg::BAC_W-1:0];
      S_OUT:   ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      idx_q           <= '0;
      wsum_q          <= '0;
      wts_q           <= '0;
      res_q           <= '0;
      div_req_q       <= '0;
    end else begin
      div_req_q.start <= 1'b0;
      if (res_q.valid && res_ready_i) res_q.valid <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (fifo_i.valid) begin
            if (fifo_i.item.start) begin
              idx_q  <= '0;
              wsum_q <= '0;
              wts_q  <= '0;
            end
            state_q <= S_VMUL;
          end
        end
        S_VMUL:  state_q <= S_VFIX;
        S_VFIX:  state_q <= S_MLO;
        S_MLO:   state_q <= S_MHI;
        S_MHI:   state_q <= S_ADD;
        S_ADD:   state_q <= (k_q == 3'd4) ? S_CLASS : S_MLO;
        S_CLASS: begin
          if ((acc_q < $signed({17'b0, min_q, 16'b0})) ||
              (acc_q > $signed({17'b0, max_q, 16'b0}))) begin
            state_q <= S_ACC;
          end else begin
            state_q <= S_BMUL;
          end
        end
        S_BMUL:  state_q <= S_BFIX;
        S_BFIX:  state_q <= S_ACC;
        S_ACC: begin
          wsum_q  <= wsum_n[bsw_pkg::WSUM_W] ? '1 : wsum_n[bsw_pkg::WSUM_W-1:0];
          wts_q   <= wts_n[bsw_pkg::WTS_W] ? '1 : wts_n[bsw_pkg::WTS_W-1:0];
          state_q <= S_MEAN;
        end
        S_MEAN: begin
          if (wts_q != '0) begin
            div_req_q.start    <= 1'b1;
            div_req_q.dividend <= {6'b0, wsum_q};
            div_req_q.divisor  <= wts_q;
            state_q            <= S_MDIV;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_MDIV:  if (div_rsp.done) state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            res_q.valid <= 1'b1;
            res_q.bac   <= mean_q;
            res_q.leds  <= bsw_pkg::leds_of(idx_q);
            res_q.over  <= over_q;
            res_q.last  <= last;
            if (last) begin
              idx_q  <= '0;
              wsum_q <= '0;
              wts_q  <= '0;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/breath_sensor_weighted_average.sv =====
// Path from input accept to result valid: S_VMUL, S_VFIX, five Horner steps
// of S_MLO, S_MHI and S_ADD, S_CLASS, S_BMUL and S_BFIX (skipped when the
// sample falls outside the ppm window), S_ACC, S_MEAN, the 48-step restoring
// divider for the weighted mean, S_OUT (waits on a held result); one item at
// a time. A 2-item queue and the output register let either side stall alone.
// Reset: asynchronous active low; clears session index, sums and queue, and
// loads vref_mv 5000, min_ppm 0, max_ppm 32767.
`include "assert_macros.svh"

module breath_sensor_weighted_average (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // [9:0] adc_code, rest zero
  input  logic                            s_axis_tuser,  // [0] start_req
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [31:0]                     m_axis_tdata,  // [19:0] running_bac,
                                                         // [24:20] progress_leds
  output logic                            m_axis_tuser,  // [0] over_range
  output logic                            m_axis_tlast,  // last_sample
  // Configuration writes
  input  logic                            cfg_we_i,
  input  logic [bsw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bsw_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  bsw_pkg::q_item_t     in_item;
  bsw_pkg::fifo_rsp_t   fifo;
  bsw_pkg::front_stat_t front_stat;
  bsw_pkg::result_t     res;
  logic                 pop;

  // Front: take items and queue them with their session-start flag.
  assign in_item.adc   = s_axis_tdata[bsw_pkg::ADC_W-1:0];
  assign in_item.start = s_axis_tuser;

  bsw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .fifo_o     (fifo),
    .pop_i      (pop),
    .stat_o     (front_stat)
  );

  // Back: scale, calibrate, weight, accumulate and emit the running mean.
  bsw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .fifo_i      (fifo),
    .pop_o       (pop),
    .res_o       (res),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tvalid = res.valid;
  assign m_axis_tdata  = {7'b0, res.leds, res.bac};
  assign m_axis_tuser  = res.over;
  assign m_axis_tlast  = res.last;

  `ASSERT_RST(a_pop_nonempty, clk_i, rst_ni, pop |-> fifo.valid, "pop from empty queue")
  `ASSERT_RST(a_queue_depth, clk_i, rst_ni, front_stat.count != 2'd3, "queue overfilled")
  `ASSERT_RST(a_led_lit, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[20], "no LED lit")

endmodule
